@@ rtl/ctt_pkg.sv @@
// Shared types and codes for the catalog text tokenizer.
// No dependencies; used by every module of the block.
package ctt_pkg;

  localparam int MANT_OUT_W  = 53;
  localparam int DEXP_W      = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_END  = 2'd1;

  localparam logic [3:0] KIND_IDENT   = 4'd0;
  localparam logic [3:0] KIND_STRING  = 4'd1;
  localparam logic [3:0] KIND_INTEGER = 4'd2;
  localparam logic [3:0] KIND_REAL    = 4'd3;
  localparam logic [3:0] KIND_LBRACE  = 4'd4;
  localparam logic [3:0] KIND_RBRACE  = 4'd5;
  localparam logic [3:0] KIND_LBRACK  = 4'd6;
  localparam logic [3:0] KIND_RBRACK  = 4'd7;
  localparam logic [3:0] KIND_END     = 4'd8;
  localparam logic [3:0] KIND_INVALID = 4'd9;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_READ     = 3'd1;
  localparam logic [2:0] ERR_BAD_CHAR = 3'd2;
  localparam logic [2:0] ERR_NUMBER   = 3'd3;
  localparam logic [2:0] ERR_EXPONENT = 3'd4;
  localparam logic [2:0] ERR_UNTERM   = 3'd5;
  localparam logic [2:0] ERR_ESCAPE   = 3'd6;

  typedef struct packed {
    logic [3:0]               kind;
    logic [7:0]               ch;
    logic                     is_text;
    logic                     last;
    logic                     neg;
    logic [MANT_OUT_W-1:0]    mant;
    logic signed [DEXP_W-1:0] dexp;
    logic                     ovf;
    logic [2:0]               err;
  } res_t;

  // One queue entry: results caused by one input byte, r0 first.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/catalog_text_tokenizer_unit.sv @@
// Catalog text tokenizer top level: lexer front, bundle queue, output stage.
// Depends on ctt_pkg, ctt_front, ctt_queue, ctt_back.
//
//   channel | dir | handshake           | payload
//   in_     | in  | in_tvalid/in_tready | tuser opcode, tdata byte
//   out_    | out | out_tvalid/tready   | tuser kind+is_text, tdata fields, tlast
//
// One byte is taken per cycle while the 4-entry bundle queue has room.
// A byte that yields two results occupies the output register with r0, then r1.
// Reset is synchronous; the lexer returns to the start-of-token state.
// A stalled output only stops input once the queue fills.
module catalog_text_tokenizer_unit import ctt_pkg::*; #(
  parameter int MANTISSA_WIDTH = 53
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [7:0] text_char, [8] negative, [61:9] mantissa,
                                  // [72:62] dec_exponent, [73] overflow, [76:74] error_code
  output logic [4:0]  out_tuser,  // [3:0] token_kind, [4] is_text
  output logic        out_tlast
);

  logic    in_acc;
  logic    q_push, q_pop;
  bundle_t q_in, q_head;
  q_stat_t q_stat;
  res_t    res;

  assign in_tready = !q_stat.full;
  assign in_acc    = in_tvalid && in_tready;

  ctt_front #(
    .MANTISSA_WIDTH (MANTISSA_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .op        (in_tuser),
    .byte_in   (in_tdata),
    .push      (q_push),
    .push_data (q_in)
  );

  ctt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  ctt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {3'b000, res.err, res.ovf, res.dexp, res.mant, res.neg, res.ch};
  assign out_tuser = {res.is_text, res.kind};
  assign out_tlast = res.last;

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("bundle pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("bundle popped from empty queue");

  a_silent_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready &&
     (out_tuser[3:0] == KIND_INVALID || out_tuser[3:0] == KIND_END)) |=> !out_tvalid)
    else $error("result after end or error token");

  a_text_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_in.two) |-> q_in.r0.last)
    else $error("second result follows an unfinished token");
`endif

endmodule

@@ rtl/ctt_front.sv @@
// Front end: lexer state machine and number accumulators.
// Classifies each accepted item and pushes its results as one bundle.
// Depends on ctt_pkg.
module ctt_front import ctt_pkg::*; #(
  parameter int MANTISSA_WIDTH = 53
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  logic [1:0] op,
  input  logic [7:0] byte_in,
  output logic      push,
  output bundle_t   push_data
);

  localparam int PW = MANTISSA_WIDTH + 4;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_UC_E   = 8'h45;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [3:0] {
    S_BEGIN, S_IDENT, S_INT, S_FRAC, S_ESIGN, S_EXP,
    S_COMMENT, S_STRING, S_ESCAPE, S_DONE
  } lex_state_t;

  lex_state_t                state_r, state_nxt;
  logic [MANTISSA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DEXP_W-1:0]         exp_r, exp_nxt;
  logic [DEXP_W-1:0]         frac_r, frac_nxt;
  logic                      neg_r, neg_nxt;
  logic                      expneg_r, expneg_nxt;
  logic                      sat_r, sat_nxt;
  logic                      sticky_r, sticky_nxt;

  function automatic res_t mk_simple(input logic [3:0] kind);
    res_t r;
    r      = '0;
    r.kind = kind;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic res_t mk_text(input logic [3:0] kind, input logic [7:0] ch);
    res_t r;
    r         = '0;
    r.kind    = kind;
    r.ch      = ch;
    r.is_text = 1'b1;
    return r;
  endfunction

  function automatic res_t mk_fail(input logic [2:0] err);
    res_t r;
    r      = mk_simple(KIND_INVALID);
    r.err  = err;
    return r;
  endfunction

  // character classes
  logic       c_digit, c_alpha, c_space, c_word, c_sep, c_e;
  logic [3:0] dval;
  assign c_digit = (byte_in >= 8'h30) && (byte_in <= 8'h39);
  assign c_alpha = ((byte_in >= 8'h61) && (byte_in <= 8'h7A)) ||
                   ((byte_in >= 8'h41) && (byte_in <= 8'h5A));
  assign c_space = (byte_in == CH_SPACE) || ((byte_in >= CH_TAB) && (byte_in <= CH_CR));
  assign c_word  = c_alpha || c_digit || (byte_in == CH_UNDER);
  assign c_sep   = !c_word && (byte_in != CH_DOT);
  assign c_e     = (byte_in == CH_LC_E) || (byte_in == CH_UC_E);
  assign dval    = byte_in[3:0];

  // mantissa and exponent multiply-add with saturation
  logic [PW-1:0]             m_prod;
  logic                      m_sat;
  logic [MANTISSA_WIDTH-1:0] m_next;
  logic [DEXP_W+3:0]         e_prod;
  logic                      e_sat;
  logic [DEXP_W-1:0]         e_next;

  assign m_prod = PW'({acc_r, 3'b000}) + PW'({acc_r, 1'b0}) + PW'(dval);
  assign m_sat  = |m_prod[PW-1:MANTISSA_WIDTH];
  assign m_next = m_sat ? '1 : m_prod[MANTISSA_WIDTH-1:0];
  assign e_prod = (DEXP_W+4)'({exp_r, 3'b000}) + (DEXP_W+4)'({exp_r, 1'b0}) +
                  (DEXP_W+4)'(dval);
  assign e_sat  = |e_prod[DEXP_W+3:DEXP_W];
  assign e_next = e_sat ? '1 : e_prod[DEXP_W-1:0];

  // finished number
  logic signed [DEXP_W+1:0] e_sum;
  logic signed [DEXP_W-1:0] e_clamp;
  logic                     e_clip;
  res_t                     num_res;

  always_comb begin
    e_sum = expneg_r ? -$signed({2'b00, exp_r}) : $signed({2'b00, exp_r});
    e_sum = e_sum - $signed({2'b00, frac_r});
    e_clip = 1'b0;
    e_clamp = e_sum[DEXP_W-1:0];
    if (e_sum > $signed((DEXP_W+2)'(1023))) begin
      e_clamp = 11'sd1023;
      e_clip  = 1'b1;
    end else if (e_sum < -$signed((DEXP_W+2)'(1024))) begin
      e_clamp = -11'sd1024;
      e_clip  = 1'b1;
    end
    num_res      = mk_simple(KIND_INTEGER);
    num_res.neg  = neg_r;
    num_res.mant = MANT_OUT_W'(acc_r);
    num_res.dexp = e_clamp;
    num_res.ovf  = sat_r || e_clip;
  end

  // start of a token
  logic       bg_v, bg_clr, bg_fail;
  res_t       bg_res;
  lex_state_t bg_state;

  always_comb begin
    bg_v     = 1'b0;
    bg_clr   = 1'b0;
    bg_fail  = 1'b0;
    bg_res   = '0;
    bg_state = S_BEGIN;
    if (c_space) begin
      bg_state = S_BEGIN;
    end else if (c_digit || byte_in == CH_MINUS || byte_in == CH_PLUS) begin
      bg_clr   = 1'b1;
      bg_state = S_INT;
    end else if (byte_in == CH_DOT) begin
      bg_clr   = 1'b1;
      bg_state = S_FRAC;
    end else if (c_alpha || byte_in == CH_UNDER) begin
      bg_v     = 1'b1;
      bg_res   = mk_text(KIND_IDENT, byte_in);
      bg_state = S_IDENT;
    end else if (byte_in == CH_HASH) begin
      bg_state = S_COMMENT;
    end else if (byte_in == CH_QUOTE) begin
      bg_state = S_STRING;
    end else if (byte_in == CH_LBRACE) begin
      bg_v   = 1'b1;
      bg_res = mk_simple(KIND_LBRACE);
    end else if (byte_in == CH_RBRACE) begin
      bg_v   = 1'b1;
      bg_res = mk_simple(KIND_RBRACE);
    end else if (byte_in == CH_LBRACK) begin
      bg_v   = 1'b1;
      bg_res = mk_simple(KIND_LBRACK);
    end else if (byte_in == CH_RBRACK) begin
      bg_v   = 1'b1;
      bg_res = mk_simple(KIND_RBRACK);
    end else begin
      bg_v    = 1'b1;
      bg_fail = 1'b1;
      bg_res  = mk_fail(ERR_BAD_CHAR);
    end
  end

  logic use_bg, bg_slot1;
  logic r0_v, r1_v;
  res_t r0, r1;

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    exp_nxt    = exp_r;
    frac_nxt   = frac_r;
    neg_nxt    = neg_r;
    expneg_nxt = expneg_r;
    sat_nxt    = sat_r;
    sticky_nxt = sticky_r;
    r0_v       = 1'b0;
    r1_v       = 1'b0;
    r0         = '0;
    r1         = '0;
    use_bg     = 1'b0;
    bg_slot1   = 1'b0;

    if (!sticky_r && state_r != S_DONE) begin
      if (op != OP_BYTE && op != OP_END) begin
        r0_v       = 1'b1;
        r0         = mk_fail(ERR_READ);
        sticky_nxt = 1'b1;
        state_nxt  = S_BEGIN;
      end else if (op == OP_END) begin
        state_nxt = S_DONE;
        case (state_r)
          S_IDENT: begin
            r0_v = 1'b1;
            r0   = mk_simple(KIND_IDENT);
            r1_v = 1'b1;
            r1   = mk_simple(KIND_END);
          end
          S_INT: begin
            r0_v = 1'b1;
            r0   = num_res;
            r1_v = 1'b1;
            r1   = mk_simple(KIND_END);
          end
          S_FRAC, S_ESIGN, S_EXP: begin
            r0_v    = 1'b1;
            r0      = num_res;
            r0.kind = KIND_REAL;
            r1_v    = 1'b1;
            r1      = mk_simple(KIND_END);
          end
          S_STRING, S_ESCAPE: begin
            r0_v       = 1'b1;
            r0         = mk_fail(ERR_UNTERM);
            sticky_nxt = 1'b1;
            state_nxt  = S_BEGIN;
          end
          default: begin
            r0_v = 1'b1;
            r0   = mk_simple(KIND_END);
          end
        endcase
      end else begin
        case (state_r)
          S_IDENT: begin
            if (c_word) begin
              r0_v = 1'b1;
              r0   = mk_text(KIND_IDENT, byte_in);
            end else begin
              r0_v     = 1'b1;
              r0       = mk_simple(KIND_IDENT);
              use_bg   = 1'b1;
              bg_slot1 = 1'b1;
            end
          end
          S_INT: begin
            if (c_digit) begin
              acc_nxt = m_next;
              sat_nxt = sat_r || m_sat;
            end else if (byte_in == CH_DOT) begin
              state_nxt = S_FRAC;
            end else if (c_e) begin
              state_nxt = S_ESIGN;
            end else if (c_sep) begin
              r0_v     = 1'b1;
              r0       = num_res;
              use_bg   = 1'b1;
              bg_slot1 = 1'b1;
            end else begin
              r0_v       = 1'b1;
              r0         = mk_fail(ERR_NUMBER);
              sticky_nxt = 1'b1;
              state_nxt  = S_BEGIN;
            end
          end
          S_FRAC: begin
            if (c_digit) begin
              acc_nxt = m_next;
              if (frac_r != '1) begin
                frac_nxt = frac_r + 1'b1;
                sat_nxt  = sat_r || m_sat;
              end else begin
                sat_nxt = 1'b1;
              end
            end else if (c_e) begin
              state_nxt = S_ESIGN;
            end else if (c_sep) begin
              r0_v     = 1'b1;
              r0       = num_res;
              r0.kind  = KIND_REAL;
              use_bg   = 1'b1;
              bg_slot1 = 1'b1;
            end else begin
              r0_v       = 1'b1;
              r0         = mk_fail(ERR_NUMBER);
              sticky_nxt = 1'b1;
              state_nxt  = S_BEGIN;
            end
          end
          S_ESIGN, S_EXP: begin
            if (state_r == S_ESIGN && byte_in == CH_MINUS) begin
              expneg_nxt = 1'b1;
              state_nxt  = S_EXP;
            end else if (state_r == S_ESIGN && byte_in == CH_PLUS) begin
              state_nxt = S_EXP;
            end else if (c_digit) begin
              exp_nxt   = e_next;
              sat_nxt   = sat_r || e_sat;
              state_nxt = S_EXP;
            end else if (c_sep) begin
              r0_v     = 1'b1;
              r0       = num_res;
              r0.kind  = KIND_REAL;
              use_bg   = 1'b1;
              bg_slot1 = 1'b1;
            end else begin
              r0_v       = 1'b1;
              r0         = mk_fail(ERR_EXPONENT);
              sticky_nxt = 1'b1;
              state_nxt  = S_BEGIN;
            end
          end
          S_COMMENT: begin
            if (byte_in == CH_LF || byte_in == CH_CR) begin
              state_nxt = S_BEGIN;
            end
          end
          S_STRING: begin
            if (byte_in == CH_QUOTE) begin
              r0_v      = 1'b1;
              r0        = mk_simple(KIND_STRING);
              state_nxt = S_BEGIN;
            end else if (byte_in == CH_BSLASH) begin
              state_nxt = S_ESCAPE;
            end else begin
              r0_v = 1'b1;
              r0   = mk_text(KIND_STRING, byte_in);
            end
          end
          S_ESCAPE: begin
            if (byte_in == CH_LC_N) begin
              r0_v      = 1'b1;
              r0        = mk_text(KIND_STRING, CH_LF);
              state_nxt = S_STRING;
            end else if (byte_in == CH_LC_T) begin
              r0_v      = 1'b1;
              r0        = mk_text(KIND_STRING, CH_TAB);
              state_nxt = S_STRING;
            end else if (byte_in == CH_BSLASH || byte_in == CH_QUOTE) begin
              r0_v      = 1'b1;
              r0        = mk_text(KIND_STRING, byte_in);
              state_nxt = S_STRING;
            end else begin
              r0_v       = 1'b1;
              r0         = mk_fail(ERR_ESCAPE);
              sticky_nxt = 1'b1;
              state_nxt  = S_BEGIN;
            end
          end
          default: begin
            use_bg = 1'b1;
          end
        endcase

        if (use_bg) begin
          state_nxt = bg_state;
          if (bg_clr) begin
            acc_nxt    = c_digit ? MANTISSA_WIDTH'(dval) : '0;
            exp_nxt    = '0;
            frac_nxt   = '0;
            neg_nxt    = (byte_in == CH_MINUS);
            expneg_nxt = 1'b0;
            sat_nxt    = 1'b0;
          end
          if (bg_fail) begin
            sticky_nxt = 1'b1;
          end
          if (bg_v) begin
            if (bg_slot1) begin
              r1_v = 1'b1;
              r1   = bg_res;
            end else begin
              r0_v = 1'b1;
              r0   = bg_res;
            end
          end
        end
      end
    end
  end

  assign push          = accept && r0_v;
  assign push_data.two = r1_v;
  assign push_data.r0  = r0;
  assign push_data.r1  = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_BEGIN;
      acc_r    <= '0;
      exp_r    <= '0;
      frac_r   <= '0;
      neg_r    <= 1'b0;
      expneg_r <= 1'b0;
      sat_r    <= 1'b0;
      sticky_r <= 1'b0;
    end else if (accept) begin
      state_r  <= state_nxt;
      acc_r    <= acc_nxt;
      exp_r    <= exp_nxt;
      frac_r   <= frac_nxt;
      neg_r    <= neg_nxt;
      expneg_r <= expneg_nxt;
      sat_r    <= sat_nxt;
      sticky_r <= sticky_nxt;
    end
  end

endmodule

@@ rtl/ctt_queue.sv @@
// Short queue of result bundles between lexer and output stage.
// Depends on ctt_pkg.
module ctt_queue import ctt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output q_stat_t stat
);

  bundle_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/ctt_back.sv @@
// Output stage: splits each bundle into single results behind a register.
// Depends on ctt_pkg.
module ctt_back import ctt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  bundle_t head,
  input  q_stat_t q_stat,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output res_t    out_res
);

  logic valid_r, valid_nxt;
  logic sel_r, sel_nxt;
  res_t res_r, res_nxt;
  logic load;

  assign load = !q_stat.empty && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    res_nxt   = res_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = sel_r ? head.r1 : head.r0;
      if (head.two && !sel_r) begin
        sel_nxt = 1'b1;
      end else begin
        sel_nxt = 1'b0;
        pop     = 1'b1;
      end
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
